// File: rtl/core/sem_pkg.sv
// Shared types, register indexes and constants for the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

    typedef logic [7:0]  t_pix;
    typedef logic [10:0] t_col_out;
    typedef logic [15:0] t_row;
    typedef logic [11:0] t_width;
    typedef logic [15:0] t_cfg_data;
    typedef logic [1:0]  t_cfg_idx;

    localparam t_cfg_idx IDX_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx IDX_IMAGE_HEIGHT = 2'd1;

    localparam t_width WIDTH_RESET  = 12'd640;
    localparam t_row   HEIGHT_RESET = 16'd480;

    localparam t_pix        MAG_MAX       = 8'd255;
    localparam logic [15:0] ROOT_BIT_INIT = 16'h4000;

    // controller -> datapath
    typedef struct packed {
        logic load;       // item accepted: latch pixel, read line store
        logic update;     // write line store, shift window, step counters
        logic grad;       // form gx, gy
        logic square;     // gx^2, gy^2
        logic sum;        // add squares, start root
        logic root_step;  // one root iteration
        logic out_load;   // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic produce;    // current item is an interior pixel's trigger
        logic root_last;  // this root iteration is the final one
        logic out_full;   // output register still holds an untaken result
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/sem_ctrl.sv
// Sequencer for the Sobel edge magnitude block: one item at a time.
`default_nettype none

module sem_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pixel_valid,
    output logic               o_pixel_ready,
    input  wire sem_pkg::t_stat i_stat,
    output sem_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_GRAD,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pixel_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.produce ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_last) n_state = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register drains
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pixel_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sem_dp.sv
// Datapath: config registers, line store, 3x3 window, gradients, root, output register.
`default_nettype none

module sem_dp #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sem_pkg::t_cmd       i_cmd,
    output sem_pkg::t_stat           o_stat,
    input  wire logic                i_cfg_we,
    input  wire sem_pkg::t_cfg_idx   i_cfg_index,
    input  wire sem_pkg::t_cfg_data  i_cfg_data,
    input  wire sem_pkg::t_pix       i_pixel_value,
    output logic                     o_result_valid,
    input  wire logic                i_result_ready,
    output sem_pkg::t_pix            o_edge_magnitude,
    output sem_pkg::t_col_out        o_center_column,
    output sem_pkg::t_row            o_center_row,
    output logic                     o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    typedef logic [CW-1:0] t_col;

    sem_pkg::t_width r_width;
    sem_pkg::t_row   r_height;
    t_col            w_last;
    sem_pkg::t_row   h_last;

    t_col            r_col;
    sem_pkg::t_row   r_row;

    logic [15:0]     r_mem [MAX_WIDTH];
    logic [15:0]     r_mem_rd;
    sem_pkg::t_pix   r_pix;
    sem_pkg::t_pix   r_win [3][3];

    sem_pkg::t_col_out r_res_col;
    sem_pkg::t_row     r_res_row;
    logic              r_res_last;

    logic [9:0]         sum_l, sum_r, sum_t, sum_b;
    logic signed [10:0] r_gx, r_gy;
    logic signed [21:0] sqx_full, sqy_full;
    logic [20:0]        r_sqx, r_sqy;
    logic [21:0]        sq_sum;
    logic               r_sat;
    logic [15:0]        r_v, r_root, r_bit, trial;

    // effective frame limits, kept as last index
    always_comb begin
        if (r_width < 12'd3) begin
            w_last = t_col'(2);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_last = t_col'(MAX_WIDTH - 1);
        end else begin
            w_last = t_col'(r_width - 12'd1);
        end
        h_last = (r_height < 16'd3) ? 16'd2 : r_height - 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_RESET;
            r_height <= sem_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sem_pkg::IDX_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[11:0];
                    r_col   <= '0;
                    r_row   <= '0;
                end
                sem_pkg::IDX_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.update) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= (r_row == h_last) ? 16'd0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + t_col'(1);
            end
        end
    end

    // line store entry: {row two up, row one up}
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_rd <= r_mem[r_col];
            r_pix    <= i_pixel_value;
        end
        if (i_cmd.update) begin
            r_mem[r_col] <= {r_mem_rd[7:0], r_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '{default: '0};
        end else if (i_cmd.update) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_mem_rd[15:8];
            r_win[1][2] <= r_mem_rd[7:0];
            r_win[2][2] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_col  <= sem_pkg::t_col_out'(r_col - t_col'(1));
            r_res_row  <= r_row - 16'd1;
            r_res_last <= (r_row == h_last) && (r_col == w_last);
        end
    end

    always_comb begin
        sum_l = {2'b0, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b0, r_win[2][0]};
        sum_r = {2'b0, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b0, r_win[2][2]};
        sum_t = {2'b0, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b0, r_win[0][2]};
        sum_b = {2'b0, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b0, r_win[2][2]};
        sqx_full = r_gx * r_gx;
        sqy_full = r_gy * r_gy;
        sq_sum   = {1'b0, r_sqx} + {1'b0, r_sqy};
        trial    = r_root + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
            r_gy <= $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
        end
        if (i_cmd.square) begin
            r_sqx <= sqx_full[20:0];
            r_sqy <= sqy_full[20:0];
        end
        if (i_cmd.sum) begin
            r_sat  <= |sq_sum[21:16];
            r_v    <= sq_sum[15:0];
            r_root <= '0;
            r_bit  <= sem_pkg::ROOT_BIT_INIT;
        end else if (i_cmd.root_step) begin
            if (r_v >= trial) begin
                r_v    <= r_v - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_edge_magnitude <= r_sat ? sem_pkg::MAG_MAX : r_root[7:0];
            o_center_column  <= r_res_col;
            o_center_row     <= r_res_row;
            o_frame_last     <= r_res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_result_valid <= 1'b1;
        end else if (i_result_ready) begin
            o_result_valid <= 1'b0;
        end
    end

    assign o_stat.produce   = (r_row >= 16'd2) && (r_col >= t_col'(2));
    assign o_stat.root_last = r_bit[0];
    assign o_stat.out_full  = o_result_valid;

endmodule

`default_nettype wire

// File: rtl/core/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream.
//
// Pixels enter in raster order on the pixel channel (valid/ready), one item
// each. Every interior pixel yields one result item: floor(sqrt(gx^2+gy^2))
// saturated to 255, its column and row, and frame_last on the final one of
// the frame. The result for a pixel appears when the pixel one row down and
// one column right is taken in; border pixels give nothing.
// Items are handled one at a time by a sequencer. A border item passes
// through accept and line store update. An interior item passes through
// accept, update, gradient, square, sum, eight iterations of the bit-serial
// root unit, and the load of the output register.
// The output register holds a finished result while the receiver stalls; the
// next pixel is taken meanwhile, and its result waits in the sequencer until
// the register drains.
// Config writes (index 0 width, 1 height) are always ready and restart the
// frame. Reset restores 640x480 and zeroes the window and counters; the line
// store needs no clearing since each frame writes a row before reading it.
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_pixel_valid,
    output logic                     o_pixel_ready,
    input  wire sem_pkg::t_pix       i_pixel_value,
    output logic                     o_result_valid,
    input  wire logic                i_result_ready,
    output sem_pkg::t_pix            o_edge_magnitude,
    output sem_pkg::t_col_out        o_center_column,
    output sem_pkg::t_row            o_center_row,
    output logic                     o_frame_last,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire sem_pkg::t_cfg_idx   i_cfg_index,
    input  wire sem_pkg::t_cfg_data  i_cfg_data
);

    sem_pkg::t_cmd  cmd;
    sem_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    sem_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    sem_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_value    (i_pixel_value),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_edge_magnitude (o_edge_magnitude),
        .o_center_column  (o_center_column),
        .o_center_row     (o_center_row),
        .o_frame_last     (o_frame_last)
    );

    // border pixels never produce a result
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_center_column != 11'd0) && (o_center_row != 16'd0))
        else $error("result for a border pixel");

    // one item in flight: the sequencer leaves idle right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pixel_valid && o_pixel_ready |=> !o_pixel_ready)
        else $error("pixel channel ready right after an accept");

    // a taken result is not followed at once by another
    a_no_back_to_back_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_ready |=> !o_result_valid)
        else $error("output register reloaded while still full");

endmodule

`default_nettype wire
